// ===== rtl/efha_pkg.sv =====
// Shared types, codes and defaults of the free-list heap allocator.
package efha_pkg;

  localparam int DEF_HEAP_WORDS   = 8192;
  localparam int OPC_W            = 2;
  localparam int SIZE_W           = 16;
  localparam int ADDR_W           = 16;
  localparam int ST_W             = 2;
  localparam int CNT_W            = 17;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  localparam logic [OPC_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OPC_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_NULL = 2'd1;
  localparam logic [ST_W-1:0] ST_OOM  = 2'd2;

  localparam logic REG_FIT_MODE = 1'b0;
  localparam logic REG_EXTEND   = 1'b1;

  localparam logic             DEF_FIT_MODE = 1'b0;
  localparam logic [CNT_W-1:0] DEF_EXTEND   = 17'd4096;

  typedef struct packed {
    logic             fit_mode;
    logic [CNT_W-1:0] extend_chunk;
  } cfg_t;

endpackage

// ===== rtl/efha_mem.sv =====
// Heap tag memory: one write port, one registered read port with write forwarding.
module efha_mem #(
  parameter int DEPTH = efha_pkg::DEF_HEAP_WORDS,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] widx,
  input  logic [31:0]   wdata,
  input  logic [IW-1:0] ridx,
  input  logic          rok,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;
  logic        rok_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    // same-cycle write to the read address wins
    if (we && (widx == ridx)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[ridx];
    end
    rok_r <= rok;
  end

  // out-of-range words read as zero
  assign rdata = rok_r ? rdata_r : 32'd0;

endmodule

// ===== rtl/efha_cfg.sv =====
// APB register file: fit mode and heap extension chunk.
module efha_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efha_pkg::PADDR_W-1:0]  paddr,
  input  logic [efha_pkg::PDATA_W-1:0]  pwdata,
  output logic [efha_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output efha_pkg::cfg_t                cfg
);
  import efha_pkg::*;

  logic             fit_r, fit_nxt;
  logic [CNT_W-1:0] ext_r, ext_nxt;
  logic             wr_go;

  assign pready = 1'b1;
  assign wr_go  = psel && penable && pwrite;

  always_comb begin
    fit_nxt = fit_r;
    ext_nxt = ext_r;
    if (wr_go) begin
      unique case (paddr[2])
        REG_FIT_MODE: fit_nxt = pwdata[0];
        REG_EXTEND:   ext_nxt = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= DEF_FIT_MODE;
      ext_r <= DEF_EXTEND;
    end else begin
      fit_r <= fit_nxt;
      ext_r <= ext_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIT_MODE: prdata = {{(PDATA_W-1){1'b0}}, fit_r};
      REG_EXTEND:   prdata = {{(PDATA_W-CNT_W){1'b0}}, ext_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.fit_mode     = fit_r;
  assign cfg.extend_chunk = ext_r;

endmodule

// ===== rtl/efha_seq.sv =====
// Allocator sequencer: init, fit search, grow, carve, release and coalesce.
module efha_seq #(
  parameter int HEAP_WORDS = efha_pkg::DEF_HEAP_WORDS,
  parameter int IW         = $clog2(HEAP_WORDS),
  parameter int AW         = (IW + 4 > 18) ? IW + 4 : 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  efha_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [efha_pkg::OPC_W-1:0]   in_opcode,
  input  logic [efha_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [efha_pkg::ADDR_W-1:0]  in_block_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [efha_pkg::ADDR_W-1:0]  out_result_address,
  output logic [efha_pkg::ST_W-1:0]    out_status,
  output logic [efha_pkg::CNT_W-1:0]   out_requested_bytes,
  output logic [efha_pkg::CNT_W-1:0]   out_heap_bytes,
  output logic                         mem_we,
  output logic [IW-1:0]                mem_widx,
  output logic [31:0]                  mem_wdata,
  output logic [IW-1:0]                mem_ridx,
  output logic                         mem_rok,
  input  logic [31:0]                  mem_rdata
);
  import efha_pkg::*;

  localparam logic [AW-1:0] CAP   = AW'(HEAP_WORDS) << 3;
  localparam int            LIMIT = HEAP_WORDS / 4 + 1;
  localparam int            NW    = $clog2(LIMIT + 1);
  localparam logic [AW-1:0] MINB  = AW'(32);

  localparam logic [5:0] S_IDLE = 6'd0,  S_I1   = 6'd1,  S_I2   = 6'd2,  S_I3   = 6'd3;
  localparam logic [5:0] S_I4   = 6'd4,  S_G0   = 6'd5,  S_G1   = 6'd6,  S_G2   = 6'd7;
  localparam logic [5:0] S_G3   = 6'd8,  S_M0   = 6'd9,  S_M1   = 6'd10, S_M2   = 6'd11;
  localparam logic [5:0] S_MPA  = 6'd12, S_MNN  = 6'd13, S_MPB  = 6'd14, S_MPBH = 6'd15;
  localparam logic [5:0] S_MPBS = 6'd16, S_MW0  = 6'd17, S_MW1  = 6'd18, S_PU0  = 6'd19;
  localparam logic [5:0] S_PU1  = 6'd20, S_PU2  = 6'd21, S_DR0  = 6'd22, S_DR1  = 6'd23;
  localparam logic [5:0] S_DR2  = 6'd24, S_DR3  = 6'd25, S_AG   = 6'd26, S_SKB  = 6'd27;
  localparam logic [5:0] S_SKC  = 6'd28, S_SKE  = 6'd29, S_C0   = 6'd30, S_C1   = 6'd31;
  localparam logic [5:0] S_C2   = 6'd32, S_C3   = 6'd33, S_C4   = 6'd34, S_C5   = 6'd35;
  localparam logic [5:0] S_CE   = 6'd36, S_R1   = 6'd37, S_R2   = 6'd38, S_R3   = 6'd39;
  localparam logic [5:0] S_DONE = 6'd40;

  function automatic logic [31:0] tag(input logic [AW-1:0] size, input logic prev,
                                      input logic alloc);
    tag = {{(32-AW){1'b0}}, size[AW-1:2], prev, alloc};
  endfunction

  function automatic logic [AW-1:0] sz_of(input logic [31:0] d);
    sz_of = {d[AW-1:3], 3'b000};
  endfunction

  // bytes/8, rounded up to an even word count, back to bytes
  function automatic logic [AW-1:0] grow_of(input logic [AW-1:0] x);
    grow_of = {x[AW-1:3] + {{(AW-4){1'b0}}, x[3]}, 3'b000};
  endfunction

  logic [5:0]       state_r, state_nxt, mret_r, mret_nxt, lret_r, lret_nxt;
  logic [OPC_W-1:0] op_r, op_nxt;
  logic [AW-1:0]    asize_r, asize_nxt, bp_r, bp_nxt, size_r, size_nxt, nsz_r, nsz_nxt;
  logic             pa_r, pa_nxt, na_r, na_nxt, grown_r, grown_nxt, ready_r, ready_nxt;
  logic [AW-1:0]    ms_r, ms_nxt, mx_r, mx_nxt, lx_r, lx_nxt, pr_r, pr_nxt, nx_r, nx_nxt;
  logic [AW-1:0]    p_r, p_nxt, best_r, best_nxt, bestsz_r, bestsz_nxt, gsz_r, gsz_nxt;
  logic [AW-1:0]    whole_r, whole_nxt, csz_r, csz_nxt, fh_r, fh_nxt, brk_r, brk_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] ucnt_r, ucnt_nxt, hcnt_r, hcnt_nxt;
  logic             ov_r, ov_nxt;
  logic [ADDR_W-1:0] oa_r, oa_nxt;
  logic [ST_W-1:0]  os_r, os_nxt;
  logic [CNT_W-1:0] ou_r, ou_nxt, oh_r, oh_nxt;

  logic [AW-1:0] rd_a, wr_a, rsz, a_in, want, rdl;
  logic          wr_en, in_go;
  logic [31:0]   wr_d;

  assign in_stall = (state_r != S_IDLE);
  assign in_go    = in_valid && !in_stall;
  assign rsz      = sz_of(mem_rdata);
  assign rdl      = mem_rdata[AW-1:0];

  always_comb begin
    a_in = (AW'(in_request_size) + AW'(23)) & ~AW'(7);
    if (a_in < MINB) a_in = MINB;
  end

  assign want = (asize_r > AW'(cfg.extend_chunk)) ? asize_r : AW'(cfg.extend_chunk);

  always_comb begin
    state_nxt = state_r;  mret_nxt = mret_r;  lret_nxt = lret_r;  op_nxt = op_r;
    asize_nxt = asize_r;  bp_nxt = bp_r;      size_nxt = size_r;  nsz_nxt = nsz_r;
    pa_nxt = pa_r;        na_nxt = na_r;      grown_nxt = grown_r; ready_nxt = ready_r;
    ms_nxt = ms_r;        mx_nxt = mx_r;      lx_nxt = lx_r;      pr_nxt = pr_r;
    nx_nxt = nx_r;        p_nxt = p_r;        best_nxt = best_r;  bestsz_nxt = bestsz_r;
    gsz_nxt = gsz_r;      whole_nxt = whole_r; csz_nxt = csz_r;   fh_nxt = fh_r;
    brk_nxt = brk_r;      n_nxt = n_r;        st_nxt = st_r;      addr_nxt = addr_r;
    ucnt_nxt = ucnt_r;    hcnt_nxt = hcnt_r;
    ov_nxt = ov_r;  oa_nxt = oa_r;  os_nxt = os_r;  ou_nxt = ou_r;  oh_nxt = oh_r;
    rd_a = '0;  wr_en = 1'b0;  wr_a = '0;  wr_d = '0;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_go) begin
          op_nxt   = in_opcode;
          st_nxt   = ST_OK;
          addr_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_opcode)
            OP_INIT: begin
              fh_nxt = '0;  brk_nxt = '0;  ucnt_nxt = '0;  hcnt_nxt = '0;
              ready_nxt = 1'b0;
              state_nxt = S_I1;
            end
            OP_ALLOC: begin
              if (in_request_size == '0) begin
                st_nxt = ST_NULL;
              end else if (!ready_r) begin
                st_nxt = ST_OOM;
              end else begin
                asize_nxt = a_in;
                p_nxt = fh_r;  n_nxt = '0;  best_nxt = '0;  bestsz_nxt = '0;
                if (fh_r == '0) begin
                  state_nxt = S_SKE;
                end else begin
                  rd_a = fh_r - AW'(8);
                  state_nxt = S_SKB;
                end
              end
            end
            OP_RELEASE: begin
              if (ready_r && (in_block_address[2:0] == 3'd0) &&
                  (AW'(in_block_address) >= MINB) && (AW'(in_block_address) < brk_r)) begin
                bp_nxt = AW'(in_block_address);
                rd_a = AW'(in_block_address) - AW'(8);
                state_nxt = S_R1;
              end
            end
            default: ;
          endcase
        end
      end
      // prologue and epilogue
      S_I1: begin wr_en = 1'b1; wr_a = AW'(0);  wr_d = 32'd0;  state_nxt = S_I2; end
      S_I2: begin wr_en = 1'b1; wr_a = AW'(8);  wr_d = tag(AW'(16), 1'b1, 1'b1); state_nxt = S_I3; end
      S_I3: begin wr_en = 1'b1; wr_a = AW'(16); wr_d = tag(AW'(16), 1'b1, 1'b1); state_nxt = S_I4; end
      S_I4: begin
        wr_en = 1'b1; wr_a = AW'(24); wr_d = tag('0, 1'b1, 1'b1);
        brk_nxt = AW'(32);  ready_nxt = 1'b1;
        gsz_nxt = grow_of(AW'(cfg.extend_chunk));
        state_nxt = S_G0;
      end
      // heap growth
      S_G0: begin
        if ((brk_r > CAP) || (gsz_r > CAP - brk_r)) begin
          st_nxt = ST_OOM;
          state_nxt = S_DONE;
        end else begin
          bp_nxt = brk_r;
          rd_a = brk_r - AW'(8);
          state_nxt = S_G1;
        end
      end
      S_G1: begin
        pa_nxt = mem_rdata[1];
        brk_nxt = brk_r + gsz_r;
        hcnt_nxt = hcnt_r + gsz_r[CNT_W-1:0];
        wr_en = 1'b1; wr_a = bp_r - AW'(8); wr_d = tag(gsz_r, mem_rdata[1], 1'b0);
        state_nxt = S_G2;
      end
      S_G2: begin
        wr_en = 1'b1; wr_a = bp_r + gsz_r - AW'(16); wr_d = tag(gsz_r, pa_r, 1'b0);
        state_nxt = S_G3;
      end
      S_G3: begin
        wr_en = 1'b1; wr_a = bp_r + gsz_r - AW'(8); wr_d = tag('0, 1'b0, 1'b1);
        mret_nxt = S_AG;
        state_nxt = S_M0;
      end
      // coalesce block at bp_r with its neighbors
      S_M0: begin rd_a = bp_r - AW'(8); state_nxt = S_M1; end
      S_M1: begin
        pa_nxt = mem_rdata[1];
        size_nxt = rsz;
        rd_a = bp_r + rsz - AW'(8);
        state_nxt = S_M2;
      end
      S_M2: begin
        na_nxt = mem_rdata[0];
        nsz_nxt = rsz;
        if (pa_r && mem_rdata[0]) begin
          mx_nxt = bp_r;  lx_nxt = bp_r;  lret_nxt = mret_r;
          state_nxt = S_PU0;
        end else if (pa_r) begin
          lx_nxt = bp_r + size_r;  lret_nxt = S_MPA;
          state_nxt = S_DR0;
        end else if (mem_rdata[0]) begin
          rd_a = bp_r - AW'(16);
          state_nxt = S_MPB;
        end else begin
          lx_nxt = bp_r + size_r;  lret_nxt = S_MNN;
          state_nxt = S_DR0;
        end
      end
      S_MPA: begin
        ms_nxt = size_r + nsz_r;  mx_nxt = bp_r;
        state_nxt = S_MW0;
      end
      S_MNN: begin rd_a = bp_r - AW'(16); state_nxt = S_MPB; end
      S_MPB: begin
        mx_nxt = bp_r - rsz;  lx_nxt = bp_r - rsz;  lret_nxt = S_MPBH;
        state_nxt = S_DR0;
      end
      S_MPBH: begin rd_a = mx_r - AW'(8); state_nxt = S_MPBS; end
      S_MPBS: begin
        ms_nxt = rsz + size_r + (na_r ? '0 : nsz_r);
        state_nxt = S_MW0;
      end
      S_MW0: begin
        wr_en = 1'b1; wr_a = mx_r - AW'(8); wr_d = tag(ms_r, 1'b1, 1'b0);
        state_nxt = S_MW1;
      end
      S_MW1: begin
        wr_en = 1'b1; wr_a = mx_r + ms_r - AW'(16); wr_d = tag(ms_r, 1'b1, 1'b0);
        lx_nxt = mx_r;  lret_nxt = mret_r;
        state_nxt = S_PU0;
      end
      // LIFO push of lx_r
      S_PU0: begin wr_en = 1'b1; wr_a = lx_r; wr_d = 32'd0; state_nxt = S_PU1; end
      S_PU1: begin
        wr_en = 1'b1; wr_a = lx_r + AW'(8); wr_d = 32'(fh_r);
        state_nxt = S_PU2;
      end
      S_PU2: begin
        if (fh_r != '0) begin
          wr_en = 1'b1; wr_a = fh_r; wr_d = 32'(lx_r);
        end
        fh_nxt = lx_r;
        state_nxt = lret_r;
      end
      // unlink lx_r
      S_DR0: begin
        if (fh_r == '0) begin
          state_nxt = lret_r;
        end else begin
          rd_a = lx_r;
          state_nxt = S_DR1;
        end
      end
      S_DR1: begin pr_nxt = rdl; rd_a = lx_r + AW'(8); state_nxt = S_DR2; end
      S_DR2: begin
        nx_nxt = rdl;
        state_nxt = lret_r;
        if ((pr_r != '0) && (rdl != '0)) begin
          wr_en = 1'b1; wr_a = pr_r + AW'(8); wr_d = 32'(rdl);
          state_nxt = S_DR3;
        end else if (pr_r != '0) begin
          wr_en = 1'b1; wr_a = pr_r + AW'(8); wr_d = 32'd0;
        end else if (rdl != '0) begin
          wr_en = 1'b1; wr_a = rdl; wr_d = 32'd0;
          fh_nxt = rdl;
        end else begin
          fh_nxt = '0;
        end
      end
      S_DR3: begin
        wr_en = 1'b1; wr_a = nx_r; wr_d = 32'(pr_r);
        state_nxt = lret_r;
      end
      S_AG: begin
        if (op_r == OP_INIT) begin
          hcnt_nxt = hcnt_r + CNT_W'(32);
          state_nxt = S_DONE;
        end else begin
          bp_nxt = mx_r;  grown_nxt = 1'b1;
          state_nxt = S_C0;
        end
      end
      // free-list walk, two reads per link
      S_SKB: begin
        rd_a = p_r + AW'(8);
        state_nxt = S_SKC;
        if (rsz >= asize_r) begin
          if (cfg.fit_mode) begin
            bp_nxt = p_r;  grown_nxt = 1'b0;
            rd_a = '0;
            state_nxt = S_C0;
          end else if ((best_r == '0) || (bestsz_r > rsz)) begin
            best_nxt = p_r;  bestsz_nxt = rsz;
          end
        end
      end
      S_SKC: begin
        n_nxt = n_r + NW'(1);
        p_nxt = rdl;
        if ((rdl == '0) || (n_r + NW'(1) == NW'(LIMIT))) begin
          state_nxt = S_SKE;
        end else begin
          rd_a = rdl - AW'(8);
          state_nxt = S_SKB;
        end
      end
      S_SKE: begin
        if (best_r != '0) begin
          bp_nxt = best_r;  grown_nxt = 1'b0;
          state_nxt = S_C0;
        end else begin
          gsz_nxt = grow_of(want);
          state_nxt = S_G0;
        end
      end
      // place asize_r bytes in block bp_r
      S_C0: begin rd_a = bp_r - AW'(8); state_nxt = S_C1; end
      S_C1: begin
        whole_nxt = rsz;  lx_nxt = bp_r;  lret_nxt = S_C2;
        state_nxt = S_DR0;
      end
      S_C2: begin
        wr_en = 1'b1; wr_a = bp_r - AW'(8);
        if (whole_r - asize_r < MINB) begin
          wr_d = tag(whole_r, 1'b1, 1'b1);
          csz_nxt = whole_r;
          rd_a = bp_r + whole_r - AW'(8);
          state_nxt = S_C3;
        end else begin
          wr_d = tag(asize_r, 1'b1, 1'b1);
          csz_nxt = asize_r;
          state_nxt = S_C4;
        end
      end
      S_C3: begin
        wr_en = 1'b1; wr_a = bp_r + whole_r - AW'(8); wr_d = mem_rdata | 32'h2;
        state_nxt = S_CE;
      end
      S_C4: begin
        wr_en = 1'b1; wr_a = bp_r + asize_r - AW'(8);
        wr_d = tag(whole_r - asize_r, 1'b1, 1'b0);
        state_nxt = S_C5;
      end
      S_C5: begin
        wr_en = 1'b1; wr_a = bp_r + whole_r - AW'(16);
        wr_d = tag(whole_r - asize_r, 1'b1, 1'b0);
        lx_nxt = bp_r + asize_r;  lret_nxt = S_CE;
        state_nxt = S_PU0;
      end
      S_CE: begin
        ucnt_nxt = ucnt_r + (grown_r ? asize_r[CNT_W-1:0] : csz_r[CNT_W-1:0]) - CNT_W'(8);
        addr_nxt = bp_r[ADDR_W-1:0];
        st_nxt = ST_OK;
        state_nxt = S_DONE;
      end
      // release checks and retag
      S_R1: begin
        state_nxt = S_DONE;
        if (mem_rdata[0] && ((mem_rdata & ~32'h7) >= 32'd32) &&
            ((mem_rdata & ~32'h7) <= 32'(brk_r - bp_r))) begin
          size_nxt = rsz;  pa_nxt = mem_rdata[1];
          wr_en = 1'b1; wr_a = bp_r - AW'(8); wr_d = tag(rsz, mem_rdata[1], 1'b0);
          state_nxt = S_R2;
        end
      end
      S_R2: begin
        wr_en = 1'b1; wr_a = bp_r + size_r - AW'(16); wr_d = tag(size_r, pa_r, 1'b0);
        rd_a = bp_r + size_r - AW'(8);
        state_nxt = S_R3;
      end
      S_R3: begin
        wr_en = 1'b1; wr_a = bp_r + size_r - AW'(8); wr_d = mem_rdata & ~32'h2;
        ucnt_nxt = ucnt_r - size_r[CNT_W-1:0] + CNT_W'(8);
        mret_nxt = S_DONE;
        state_nxt = S_M0;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          oa_nxt = addr_r;  os_nxt = st_r;  ou_nxt = ucnt_r;  oh_nxt = hcnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign mem_we    = wr_en && (wr_a < CAP);
  assign mem_widx  = wr_a[IW+2:3];
  assign mem_wdata = wr_d;
  assign mem_ridx  = rd_a[IW+2:3];
  assign mem_rok   = (rd_a < CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  ready_r <= 1'b0;  fh_r <= '0;  brk_r <= '0;
      ucnt_r <= '0;  hcnt_r <= '0;  ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  ready_r <= ready_nxt;  fh_r <= fh_nxt;  brk_r <= brk_nxt;
      ucnt_r <= ucnt_nxt;  hcnt_r <= hcnt_nxt;  ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mret_r <= mret_nxt;  lret_r <= lret_nxt;  op_r <= op_nxt;  asize_r <= asize_nxt;
    bp_r <= bp_nxt;  size_r <= size_nxt;  nsz_r <= nsz_nxt;  pa_r <= pa_nxt;
    na_r <= na_nxt;  grown_r <= grown_nxt;  ms_r <= ms_nxt;  mx_r <= mx_nxt;
    lx_r <= lx_nxt;  pr_r <= pr_nxt;  nx_r <= nx_nxt;  p_r <= p_nxt;
    best_r <= best_nxt;  bestsz_r <= bestsz_nxt;  gsz_r <= gsz_nxt;
    whole_r <= whole_nxt;  csz_r <= csz_nxt;  n_r <= n_nxt;  st_r <= st_nxt;
    addr_r <= addr_nxt;  oa_r <= oa_nxt;  os_r <= os_nxt;  ou_r <= ou_nxt;
    oh_r <= oh_nxt;
  end

  assign out_valid           = ov_r;
  assign out_result_address  = oa_r;
  assign out_status          = os_r;
  assign out_requested_bytes = ou_r;
  assign out_heap_bytes      = oh_r;

  a_busy_after_go: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> (state_r != S_IDLE))
    else $error("sequencer idle right after a transfer");

  a_not_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ready_r |-> ((fh_r == '0) && (brk_r == '0)))
    else $error("heap state present before init completed");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside completion");

  a_brk_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (brk_r <= CAP) && (fh_r < CAP))
    else $error("break or free head beyond heap");

endmodule

// ===== rtl/explicit_free_list_heap_allocator.sv =====
// Top level of the explicit free-list heap allocator with boundary tags.
//
// Usage: one item per in_ transfer (opcode, request_size, block_address),
// one result per item on the out_ channel (result_address, status and the
// running requested/heap byte counts). Both channels transfer when valid is
// high and stall is low. Items are processed one at a time; in_stall is low
// only while the sequencer is idle, and a finished result waits in the
// output register so the next item can be taken while it is held.
// An init writes the prologue and epilogue, then a first growth unless it
// does not fit; a release runs its checks and, if they pass, the coalesce
// case; an allocate of zero size or before init answers without a walk,
// else it walks the free-list links (at most HEAP_WORDS/4+1 of them). One
// link costs two reads of the single tag memory port.
// Reset clears the control state and the counts; the heap memory is not
// cleared, so an init item must come first (allocate before init answers
// out of memory, release before init is ignored). While out_stall holds a
// result, the next item completes its work and then waits.
// Configuration goes through the APB port (fit mode at 0x0, extension chunk
// at 0x4); the user must write only while the block is idle, not enforced.
module explicit_free_list_heap_allocator #(
  parameter int HEAP_WORDS = efha_pkg::DEF_HEAP_WORDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [efha_pkg::PADDR_W-1:0]  paddr,
  input  logic [efha_pkg::PDATA_W-1:0]  pwdata,
  output logic [efha_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [efha_pkg::OPC_W-1:0]    in_opcode,
  input  logic [efha_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [efha_pkg::ADDR_W-1:0]   in_block_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [efha_pkg::ADDR_W-1:0]   out_result_address,
  output logic [efha_pkg::ST_W-1:0]     out_status,
  output logic [efha_pkg::CNT_W-1:0]    out_requested_bytes,
  output logic [efha_pkg::CNT_W-1:0]    out_heap_bytes
);
  import efha_pkg::*;

  localparam int IW = $clog2(HEAP_WORDS);

  cfg_t          cfg;
  logic          mem_we, mem_rok;
  logic [IW-1:0] mem_widx, mem_ridx;
  logic [31:0]   mem_wdata, mem_rdata;

  // register file
  efha_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // sequencer: all heap tag traffic goes through the single memory below
  efha_seq #(.HEAP_WORDS(HEAP_WORDS), .IW(IW)) u_seq (
    .clk, .rst_n, .cfg,
    .in_valid, .in_stall, .in_opcode, .in_request_size, .in_block_address,
    .out_valid, .out_stall, .out_result_address, .out_status,
    .out_requested_bytes, .out_heap_bytes,
    .mem_we, .mem_widx, .mem_wdata, .mem_ridx, .mem_rok, .mem_rdata
  );

  // tag words, one per 8 bytes of heap
  efha_mem #(.DEPTH(HEAP_WORDS), .IW(IW)) u_mem (
    .clk, .we(mem_we), .widx(mem_widx), .wdata(mem_wdata),
    .ridx(mem_ridx), .rok(mem_rok), .rdata(mem_rdata)
  );

endmodule
